/* rtl/core/cfms_pkg.sv */
// ---------------------------------------------------------------------------
// Cube face move sequencer package
// Shared types, command codes and the reset face order for the sequencer.
// ---------------------------------------------------------------------------
package cfms_pkg;

    localparam int NUM_FACES = 6;
    localparam int POS_W     = 3;

    typedef logic [7:0] letter_t;

    // ASCII face letters, in their order after reset.
    localparam letter_t LETTER_F = 8'h46;
    localparam letter_t LETTER_R = 8'h52;
    localparam letter_t LETTER_D = 8'h44;
    localparam letter_t LETTER_L = 8'h4C;
    localparam letter_t LETTER_U = 8'h55;
    localparam letter_t LETTER_B = 8'h42;

    localparam letter_t FACE_RESET [NUM_FACES] =
        '{LETTER_F, LETTER_R, LETTER_D, LETTER_L, LETTER_U, LETTER_B};

    // ASCII turn codes.
    localparam letter_t TURN_QUARTER_S = 8'h31;
    localparam letter_t TURN_HALF      = 8'h32;
    localparam letter_t TURN_QUARTER_N = 8'h33;

    // Face positions in the table.
    localparam logic [POS_W-1:0] POS_FRONT = 3'd0;
    localparam logic [POS_W-1:0] POS_ONE   = 3'd1;
    localparam logic [POS_W-1:0] POS_TWO   = 3'd2;
    localparam logic [POS_W-1:0] POS_THREE = 3'd3;
    localparam logic [POS_W-1:0] POS_FOUR  = 3'd4;
    localparam logic [POS_W-1:0] POS_FIVE  = 3'd5;

    localparam logic HAND_L = 1'b0;
    localparam logic HAND_R = 1'b1;
    localparam logic DIR_S  = 1'b0;
    localparam logic DIR_N  = 1'b1;

    localparam logic [1:0] ACT_OPEN  = 2'd0;
    localparam logic [1:0] ACT_CLOSE = 2'd1;
    localparam logic [1:0] ACT_ROT   = 2'd2;

    typedef struct packed {
        letter_t face_letter;
        letter_t turn_code;
    } item_t;

    typedef struct packed {
        logic       hand;
        logic [1:0] action;
        logic       direction;
        logic       half_turn;
        logic       alt_profile;
        logic       last;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PRE_OPEN,
        ST_PRE_HOME,
        ST_PRE_ROT,
        ST_PRE_CLOSE,
        ST_HOME_OPEN,
        ST_HOME_ROT,
        ST_HOME_CLOSE,
        ST_TURN
    } state_t;

    typedef struct packed {
        logic   load;
        logic   advance;
        state_t step;
    } dp_cmd_t;

    typedef struct packed {
        logic emit;
        logic slot_free;
        logic has_pre;
        logic home_needed;
    } dp_status_t;

endpackage

/* rtl/core/cfms_dp.sv */
// ---------------------------------------------------------------------------
// Cube face move sequencer datapath
// Holds the face table, hand flags and the output register, and builds the
// gripper command for each step that the controller names.
// ---------------------------------------------------------------------------
module cfms_dp (
    input  logic             aclk,
    input  logic             aresetn,
    input  cfms_pkg::dp_cmd_t    cmd,
    output cfms_pkg::dp_status_t status,
    input  cfms_pkg::item_t  s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output cfms_pkg::result_t m_data
);
    import cfms_pkg::*;

    letter_t          face_order_reg [NUM_FACES];
    letter_t          face_order_next [NUM_FACES];
    logic [1:0]       turned_reg, turned_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    letter_t          code_reg, code_next;
    logic             m_valid_reg, m_valid_next;
    result_t          m_data_reg, m_data_next;

    logic       has_pre, hand_a, hand_face, hand_other, dir_pre, half_pre;
    logic       flag_a, flag_other;
    logic       turn_valid, turn_dir, turn_half;
    logic       emit;
    result_t    word;
    logic [1:0] flag_clr, flag_tgl;
    logic       slot_free;

    // Per-position pattern: the pre-phase releases hand A, turns the cube
    // with the other hand, then the face is turned by the face hand.
    always_comb begin
        has_pre   = 1'b0;
        hand_a    = HAND_R;
        dir_pre   = DIR_S;
        half_pre  = 1'b0;
        hand_face = HAND_L;
        unique case (pos_reg)
            POS_FRONT: begin
                hand_face = HAND_L;
            end
            POS_ONE: begin
                has_pre   = 1'b1;
                half_pre  = 1'b1;
                hand_face = HAND_R;
            end
            POS_TWO: begin
                has_pre   = 1'b1;
                hand_face = HAND_R;
            end
            POS_THREE: begin
                hand_face = HAND_R;
            end
            POS_FOUR: begin
                has_pre   = 1'b1;
                dir_pre   = DIR_N;
                hand_face = HAND_R;
            end
            POS_FIVE: begin
                has_pre   = 1'b1;
                hand_a    = HAND_L;
                half_pre  = 1'b1;
                hand_face = HAND_L;
            end
            default: begin
                has_pre = 1'b0;
            end
        endcase
    end

    assign hand_other = ~hand_face;
    assign flag_a     = turned_reg[hand_a];
    assign flag_other = turned_reg[hand_other];
    assign turn_dir   = (code_reg == TURN_QUARTER_N);
    assign turn_half  = (code_reg == TURN_HALF);
    assign turn_valid = (code_reg == TURN_QUARTER_S) || turn_dir || turn_half;
    assign slot_free  = !m_valid_reg || m_ready;

    always_comb begin
        emit     = 1'b0;
        word     = '0;
        flag_clr = 2'b00;
        flag_tgl = 2'b00;
        unique case (cmd.step)
            ST_IDLE: begin
                emit = 1'b0;
            end
            ST_PRE_OPEN: begin
                emit        = has_pre;
                word.hand   = hand_a;
                word.action = ACT_OPEN;
            end
            ST_PRE_HOME: begin
                emit           = has_pre && flag_a;
                word.hand      = hand_a;
                word.action    = ACT_ROT;
                word.direction = DIR_N;
                flag_clr[hand_a] = has_pre;
            end
            ST_PRE_ROT: begin
                emit             = has_pre;
                word.hand        = ~hand_a;
                word.action      = ACT_ROT;
                word.direction   = dir_pre;
                word.half_turn   = half_pre;
                word.alt_profile = 1'b1;
                flag_tgl[~hand_a] = has_pre && !half_pre;
            end
            ST_PRE_CLOSE: begin
                emit        = has_pre;
                word.hand   = hand_a;
                word.action = ACT_CLOSE;
                word.last   = !flag_other && !turn_valid;
            end
            ST_HOME_OPEN: begin
                emit        = flag_other;
                word.hand   = hand_other;
                word.action = ACT_OPEN;
            end
            ST_HOME_ROT: begin
                emit           = flag_other;
                word.hand      = hand_other;
                word.action    = ACT_ROT;
                word.direction = DIR_N;
            end
            ST_HOME_CLOSE: begin
                emit        = flag_other;
                word.hand   = hand_other;
                word.action = ACT_CLOSE;
                word.last   = !turn_valid;
                flag_clr[hand_other] = 1'b1;
            end
            ST_TURN: begin
                emit           = turn_valid;
                word.hand      = hand_face;
                word.action    = ACT_ROT;
                word.direction = turn_dir;
                word.half_turn = turn_half;
                word.last      = 1'b1;
                flag_tgl[hand_face] = turn_valid && !turn_half;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_comb begin
        pos_next  = pos_reg;
        code_next = code_reg;
        if (cmd.load) begin
            code_next = s_data.turn_code;
            // Scanning downwards leaves the lowest matching position.
            for (int i = NUM_FACES - 1; i >= 0; i--) begin
                if (face_order_reg[i] == s_data.face_letter) begin
                    pos_next = POS_W'(i);
                end
            end
        end
    end

    always_comb begin
        turned_next = turned_reg;
        if (cmd.advance) begin
            turned_next = (turned_reg & ~flag_clr) ^ flag_tgl;
        end
    end

    always_comb begin
        face_order_next = face_order_reg;
        if (cmd.advance && (cmd.step == ST_TURN)) begin
            unique case (pos_reg)
                POS_ONE: begin
                    face_order_next[1] = face_order_reg[3];
                    face_order_next[3] = face_order_reg[1];
                    face_order_next[2] = face_order_reg[4];
                    face_order_next[4] = face_order_reg[2];
                end
                POS_TWO: begin
                    face_order_next[1] = face_order_reg[4];
                    face_order_next[2] = face_order_reg[1];
                    face_order_next[3] = face_order_reg[2];
                    face_order_next[4] = face_order_reg[3];
                end
                POS_FOUR: begin
                    face_order_next[1] = face_order_reg[2];
                    face_order_next[2] = face_order_reg[3];
                    face_order_next[3] = face_order_reg[4];
                    face_order_next[4] = face_order_reg[1];
                end
                POS_FIVE: begin
                    face_order_next[2] = face_order_reg[4];
                    face_order_next[4] = face_order_reg[2];
                    face_order_next[0] = face_order_reg[5];
                    face_order_next[5] = face_order_reg[0];
                end
                default: begin
                    face_order_next = face_order_reg;
                end
            endcase
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        if (cmd.advance && emit) begin
            m_valid_next = 1'b1;
            m_data_next  = word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            face_order_reg <= FACE_RESET;
            turned_reg     <= 2'b00;
            pos_reg        <= POS_FRONT;
            m_valid_reg    <= 1'b0;
        end else begin
            face_order_reg <= face_order_next;
            turned_reg     <= turned_next;
            pos_reg        <= pos_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        code_reg   <= code_next;
        m_data_reg <= m_data_next;
    end

    assign status.emit        = emit;
    assign status.slot_free   = slot_free;
    assign status.has_pre     = has_pre;
    assign status.home_needed = flag_other;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* rtl/core/cfms_ctrl.sv */
// ---------------------------------------------------------------------------
// Cube face move sequencer controller
// Walks the steps of one move, skipping the phases that the pattern lacks.
// ---------------------------------------------------------------------------
module cfms_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output cfms_pkg::dp_cmd_t    cmd,
    input  cfms_pkg::dp_status_t status
);
    import cfms_pkg::*;

    state_t state_reg, state_next;
    logic   step_go;

    // A step moves on when it has nothing to send or the output slot is free.
    assign step_go = (state_reg != ST_IDLE) && (!status.emit || status.slot_free);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_PRE_OPEN;
                end
            end
            ST_PRE_OPEN: begin
                if (step_go) begin
                    if (status.has_pre) begin
                        state_next = ST_PRE_HOME;
                    end else if (status.home_needed) begin
                        state_next = ST_HOME_OPEN;
                    end else begin
                        state_next = ST_TURN;
                    end
                end
            end
            ST_PRE_HOME: begin
                if (step_go) begin
                    state_next = ST_PRE_ROT;
                end
            end
            ST_PRE_ROT: begin
                if (step_go) begin
                    state_next = ST_PRE_CLOSE;
                end
            end
            ST_PRE_CLOSE: begin
                if (step_go) begin
                    state_next = status.home_needed ? ST_HOME_OPEN : ST_TURN;
                end
            end
            ST_HOME_OPEN: begin
                if (step_go) begin
                    state_next = ST_HOME_ROT;
                end
            end
            ST_HOME_ROT: begin
                if (step_go) begin
                    state_next = ST_HOME_CLOSE;
                end
            end
            ST_HOME_CLOSE: begin
                if (step_go) begin
                    state_next = ST_TURN;
                end
            end
            ST_TURN: begin
                if (step_go) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready     = (state_reg == ST_IDLE);
        cmd.load    = s_valid && (state_reg == ST_IDLE);
        cmd.advance = step_go;
        cmd.step    = state_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/core/cube_face_move_sequencer.sv */
// A new request is taken only in the idle state, once the previous run is
// through. The step sequencer sends at most one gripper command per cycle.
// Output stalls hold the current step until the output register drains.
// Reset (aresetn low, synchronous) restores the face order F R D L U B, clears
// both hand flags and the last position, and empties the output register.
// ---------------------------------------------------------------------------
// Cube face move sequencer
// Turns a face letter and turn code into a run of gripper commands.
// ---------------------------------------------------------------------------
module cube_face_move_sequencer (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  cfms_pkg::item_t   s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output cfms_pkg::result_t m_data
);
    import cfms_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    cfms_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .status  (status)
    );

    cfms_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .status  (status),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

/* rtl/core/cfms_checker.sv */
// ---------------------------------------------------------------------------
// Cube face move sequencer checker
// Port-level properties of the sequencer, bound to the top level.
// ---------------------------------------------------------------------------
module cfms_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input cfms_pkg::result_t m_data
);
    import cfms_pkg::*;

    // A stalled command must not change.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled command changed");

    // One request at a time: the block is busy right after taking one.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while a run was still due");

    // While a command that is not the final one waits, the run is unfinished.
    a_busy_mid_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.last |-> !s_ready)
        else $error("ready for a new request in the middle of a run");

    // After reset the block is empty and ready.
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("block not empty after reset");

endmodule

bind cube_face_move_sequencer cfms_checker u_cfms_checker (.*);
